FILE: design/dlf_pkg.sv
// dlf_pkg: shared types and constants of the dense layer forward unit
// beat payload structs, command codes, sequencer states, register indexes
// no dependencies
package dlf_pkg;

    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_OUTPUTS = 16;

    localparam int CFG_W   = 5;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 32;

    // configuration register indexes, word aligned on paddr[2]
    localparam logic REG_INPUTS  = 1'b0;
    localparam logic REG_OUTPUTS = 1'b1;

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_INPUT   = 2'd2,
        CMD_COMPUTE = 2'd3
    } dlf_cmd_t;

    typedef struct packed {
        dlf_cmd_t                   command;
        logic [3:0]                 out_node;
        logic [3:0]                 in_node;
        logic signed [VALUE_W-1:0]  value;
    } dlf_in_t;

    typedef struct packed {
        logic [3:0]                 node_index;
        logic signed [SUM_W-1:0]    weighted_sum;
        logic                       last;
    } dlf_out_t;

    // tag that travels with one store read through the mac pipeline
    typedef struct packed {
        logic vld;
        logic first;   // bias beat, restarts the accumulator
        logic last;    // closes the node
    } dlf_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN
    } dlf_state_t;

endpackage

FILE: design/dlf_store.sv
// dlf_store: weight, bias and input memories with registered reads
// depends on dlf_pkg
module dlf_store #(
    parameter int MAX_INPUTS  = dlf_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = dlf_pkg::DEF_MAX_OUTPUTS,
    localparam int IDX_I_W = (MAX_INPUTS  > 1) ? $clog2(MAX_INPUTS)  : 1,
    localparam int IDX_O_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
    input  logic                                  aclk,
    input  logic                                  ld_en,
    input  dlf_pkg::dlf_in_t                      ld_item,
    input  logic                                  rd_en,
    input  logic [IDX_O_W-1:0]                    rd_node,
    input  logic [IDX_I_W-1:0]                    rd_in,
    output logic signed [dlf_pkg::VALUE_W-1:0]    weight_q,
    output logic signed [dlf_pkg::VALUE_W-1:0]    input_q,
    output logic signed [dlf_pkg::VALUE_W-1:0]    bias_q
);
    import dlf_pkg::*;

    localparam int I_DEPTH = 2 ** IDX_I_W;
    localparam int O_DEPTH = 2 ** IDX_O_W;
    localparam int W_DEPTH = O_DEPTH * I_DEPTH;

    logic [VALUE_W-1:0] wmem [W_DEPTH];
    logic [VALUE_W-1:0] bmem [O_DEPTH];
    logic [VALUE_W-1:0] imem [I_DEPTH];

    logic                 out_ok;
    logic                 in_ok;
    logic [IDX_O_W-1:0]   wr_node;
    logic [IDX_I_W-1:0]   wr_in;

    assign out_ok  = 32'(ld_item.out_node) < 32'(MAX_OUTPUTS);
    assign in_ok   = 32'(ld_item.in_node)  < 32'(MAX_INPUTS);
    assign wr_node = IDX_O_W'(ld_item.out_node);
    assign wr_in   = IDX_I_W'(ld_item.in_node);

    always_ff @(posedge aclk) begin
        if (ld_en && ld_item.command == CMD_WEIGHT && out_ok && in_ok) begin
            wmem[{wr_node, wr_in}] <= ld_item.value;
        end
        if (rd_en) begin
            weight_q <= wmem[{rd_node, rd_in}];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_en && ld_item.command == CMD_BIAS && out_ok) begin
            bmem[wr_node] <= ld_item.value;
        end
        if (rd_en) begin
            bias_q <= bmem[rd_node];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_en && ld_item.command == CMD_INPUT && in_ok) begin
            imem[wr_in] <= ld_item.value;
        end
        if (rd_en) begin
            input_q <= imem[rd_in];
        end
    end

endmodule

FILE: design/dlf_mac.sv
// dlf_mac: multiply, accumulate and saturate pipeline behind the store reads
// depends on dlf_pkg
module dlf_mac #(
    parameter int MAX_INPUTS = dlf_pkg::DEF_MAX_INPUTS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dlf_pkg::dlf_beat_t                    issue,
    input  logic signed [dlf_pkg::VALUE_W-1:0]    weight_q,
    input  logic signed [dlf_pkg::VALUE_W-1:0]    input_q,
    input  logic signed [dlf_pkg::VALUE_W-1:0]    bias_q,
    output logic                                  res_vld,
    output logic signed [dlf_pkg::SUM_W-1:0]      res_sum
);
    import dlf_pkg::*;

    // room for MAX_INPUTS full scale products plus the scaled bias
    localparam int ACC_W = SUM_W + 1 + $clog2(MAX_INPUTS + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(33'sh0_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-33'sh0_8000_0000);

    dlf_beat_t                 rd_tag_reg;
    dlf_beat_t                 p_tag_reg;
    logic signed [SUM_W-1:0]   prod_reg;
    logic                      a_last_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      res_vld_reg;
    logic signed [SUM_W-1:0]   res_sum_reg;
    logic signed [SUM_W-1:0]   sat_val;

    // tags: memory data shows up in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg  <= '0;
            p_tag_reg   <= '0;
            a_last_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            rd_tag_reg  <= issue;
            p_tag_reg   <= rd_tag_reg;
            a_last_reg  <= p_tag_reg.vld && p_tag_reg.last;
            res_vld_reg <= a_last_reg;
        end
    end

    // product stage: bias beat turns Q8.8 bias into Q16.16
    always_ff @(posedge aclk) begin
        if (rd_tag_reg.first) begin
            prod_reg <= {{8{bias_q[VALUE_W-1]}}, bias_q, 8'h00};
        end else begin
            prod_reg <= input_q * weight_q;
        end
    end

    always_comb begin
        if (p_tag_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (p_tag_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        if (acc_reg > SAT_HI) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (acc_reg < SAT_LO) begin
            sat_val = -32'sh8000_0000;
        end else begin
            sat_val = SUM_W'(acc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (a_last_reg) begin
            res_sum_reg <= sat_val;
        end
    end

    assign res_vld = res_vld_reg;
    assign res_sum = res_sum_reg;

endmodule

FILE: design/dense_layer_forward_unit.sv
// dense_layer_forward_unit: fully connected layer, bias plus dot product
// Q8.8 in, saturated Q16.16 out. depends on dlf_pkg, dlf_store, dlf_mac
//
// usage
//   s_ channel: one command beat per item. weight, bias and input loads are
//   written into the stores in the cycle they are accepted and give no result.
//   a compute beat emits one m_ beat per output node 0 .. outputs_in_use-1,
//   with last set on the final one.
//   apb registers: 0x0 inputs_in_use, 0x4 outputs_in_use (5 bits, reset 16),
//   values above the store size act as the store size.
// timing
//   loads are accepted back to back while the sequencer is idle.
//   a compute walks the stores one entry a cycle: per node one bias read, then
//   inputs_in_use weight/input reads, then the multiply, accumulate, saturate
//   and output stages. s_ready stays low until the last node's result lands in
//   the output register.
// reset and stall
//   reset clears control and sets the apb registers to 16; stores stay unknown until loaded.
//   a node starts only once the output register is empty, so a stalled
//   receiver holds the compute with no loss; loads still go while the last
//   result waits.
module dense_layer_forward_unit #(
    parameter int MAX_INPUTS  = dlf_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = dlf_pkg::DEF_MAX_OUTPUTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dlf_pkg::dlf_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output dlf_pkg::dlf_out_t m_payload,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dlf_pkg::*;

    localparam int IDX_I_W = (MAX_INPUTS  > 1) ? $clog2(MAX_INPUTS)  : 1;
    localparam int IDX_O_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CNT_I_W = $clog2(MAX_INPUTS + 1);
    localparam int CNT_O_W = $clog2(MAX_OUTPUTS + 1);

    dlf_state_t            state_reg, state_next;
    logic [CFG_W-1:0]      cfg_in_reg, cfg_out_reg;
    logic [CNT_I_W-1:0]    ni_reg, ni_next;
    logic [CNT_O_W-1:0]    no_reg, no_next;
    logic [IDX_O_W-1:0]    node_reg, node_next;
    logic [IDX_I_W-1:0]    in_reg, in_next;
    logic                  m_valid_reg;
    dlf_out_t              m_payload_reg;

    logic                  s_fire;
    logic                  ld_en;
    logic                  cfg_wr;
    logic                  node_last;
    logic                  in_last;
    logic [CNT_I_W-1:0]    ni_clamp;
    logic [CNT_O_W-1:0]    no_clamp;
    dlf_beat_t             issue;
    logic                  res_vld;
    logic signed [SUM_W-1:0] res_sum;
    logic signed [VALUE_W-1:0] weight_q, input_q, bias_q;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_in_reg  <= CFG_W'(16);
            cfg_out_reg <= CFG_W'(16);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_INPUTS:  cfg_in_reg  <= pwdata[CFG_W-1:0];
                REG_OUTPUTS: cfg_out_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INPUTS:  prdata = 32'(cfg_in_reg);
            REG_OUTPUTS: prdata = 32'(cfg_out_reg);
            default:     prdata = '0;
        endcase
    end

    assign ni_clamp = (32'(cfg_in_reg) > 32'(MAX_INPUTS))
                      ? CNT_I_W'(MAX_INPUTS) : CNT_I_W'(cfg_in_reg);
    assign no_clamp = (32'(cfg_out_reg) > 32'(MAX_OUTPUTS))
                      ? CNT_O_W'(MAX_OUTPUTS) : CNT_O_W'(cfg_out_reg);

    // ---------------- sequencer ----------------
    // stores are written only in idle, so reads never overlap a load
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign ld_en     = s_fire && s_payload.command != CMD_COMPUTE;
    assign node_last = (CNT_O_W'(node_reg) + CNT_O_W'(1)) == no_reg;
    assign in_last   = (CNT_I_W'(in_reg) + CNT_I_W'(1)) == ni_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ni_reg    <= '0;
            no_reg    <= '0;
            node_reg  <= '0;
            in_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ni_reg    <= ni_next;
            no_reg    <= no_next;
            node_reg  <= node_next;
            in_reg    <= in_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ni_next    = ni_reg;
        no_next    = no_reg;
        node_next  = node_reg;
        in_next    = in_reg;
        issue      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_payload.command == CMD_COMPUTE) begin
                    ni_next   = ni_clamp;
                    no_next   = no_clamp;
                    node_next = '0;
                    if (no_clamp != '0) begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                // output register stays ours once it is empty
                if (!m_valid_reg) begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS: begin
                issue.vld   = 1'b1;
                issue.first = 1'b1;
                issue.last  = (ni_reg == '0);
                in_next     = '0;
                state_next  = (ni_reg == '0) ? ST_DRAIN : ST_MAC;
            end
            ST_MAC: begin
                issue.vld  = 1'b1;
                issue.last = in_last;
                if (in_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    in_next = in_reg + IDX_I_W'(1);
                end
            end
            ST_DRAIN: begin
                if (res_vld) begin
                    if (node_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        node_next  = node_reg + IDX_O_W'(1);
                        state_next = ST_WAIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    dlf_store #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_store (
        .aclk     (aclk),
        .ld_en    (ld_en),
        .ld_item  (s_payload),
        .rd_en    (issue.vld),
        .rd_node  (node_reg),
        .rd_in    (in_reg),
        .weight_q (weight_q),
        .input_q  (input_q),
        .bias_q   (bias_q)
    );

    dlf_mac #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .weight_q (weight_q),
        .input_q  (input_q),
        .bias_q   (bias_q),
        .res_vld  (res_vld),
        .res_sum  (res_sum)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_vld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_vld) begin
            m_payload_reg.node_index   <= 4'(node_reg);
            m_payload_reg.weighted_sum <= res_sum;
            m_payload_reg.last         <= node_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ---------------- assertions ----------------
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> !m_valid_reg)
        else $error("result arrived while output register still full");

    a_res_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |-> state_reg == ST_DRAIN)
        else $error("result outside drain");

    a_mac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MAC |-> CNT_I_W'(in_reg) < ni_reg)
        else $error("input index beyond inputs in use");

    a_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BIAS |-> CNT_O_W'(node_reg) < no_reg)
        else $error("node index beyond outputs in use");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_vld |=> !res_vld)
        else $error("two results back to back");

endmodule
